[rtl/lphs_pkg.sv]
// lphs_pkg: shared types and constants for the linear probing hash set
// no dependencies; imported by the interfaces and every module of the block
package lphs_pkg;

  localparam int DefaultTableSlots = 1024;
  localparam int ProbeStride       = 1;
  localparam int KeyW              = 64;
  localparam int HashW             = 32;
  localparam int CountW            = 11;
  localparam int TotalW            = 32;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_PROBE = 3'b100
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic advance;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic hit_empty;
    logic hit_match;
    logic wrap_full;
    logic out_free;
  } stat_t;

endpackage

[rtl/lphs_if.sv]
// lphs_if: valid/ready channel interfaces for requests and responses
// depends on lphs_pkg
interface lphs_req_if
  import lphs_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            operation;
  logic [KeyW-1:0]  key_value;
  logic [HashW-1:0] key_hash;

  modport source (output valid, operation, key_value, key_hash, input ready);
  modport sink   (input valid, operation, key_value, key_hash, output ready);
endinterface

interface lphs_rsp_if
  import lphs_pkg::*;
#(
  parameter int SLOT_W = $clog2(DefaultTableSlots)
);
  logic              valid;
  logic              ready;
  status_e           status;
  logic [SLOT_W-1:0] slot_index;
  logic [SLOT_W:0]   probe_steps;
  logic [CountW-1:0] key_count;
  logic [CountW-1:0] collision_count;
  logic [TotalW-1:0] total_probe_count;

  modport source (output valid, status, slot_index, probe_steps, key_count,
                  collision_count, total_probe_count, input ready);
  modport sink   (input valid, status, slot_index, probe_steps, key_count,
                  collision_count, total_probe_count, output ready);
endinterface

[rtl/lphs_ctrl.sv]
// lphs_ctrl: sequencer for the clearing pass and the slot-by-slot probe
// depends on lphs_pkg; drives the command struct of lphs_datapath
module lphs_ctrl
  import lphs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   stop;

  assign stop = stat_i.hit_empty | stat_i.hit_match | stat_i.wrap_full;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stop) begin
          // hold on the current slot until the response register frees up
          if (stat_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/lphs_datapath.sv]
// lphs_datapath: slot memory, probe position and step registers, counters
// and the response register; depends on lphs_pkg, commanded by lphs_ctrl
module lphs_datapath
  import lphs_pkg::*;
#(
  parameter int TABLE_SLOTS = DefaultTableSlots,
  parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              op_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [HashW-1:0]  hash_i,
  input  logic              rsp_ready_i,
  output logic              rsp_valid_o,
  output status_e           status_o,
  output logic [SLOT_W-1:0] slot_index_o,
  output logic [SLOT_W:0]   probe_steps_o,
  output logic [CountW-1:0] key_count_o,
  output logic [CountW-1:0] collision_count_o,
  output logic [TotalW-1:0] total_probe_count_o
);

  localparam int EntryW = KeyW + 1;

  // each entry holds the occupied mark on top of the key
  logic [EntryW-1:0] key_mem [TABLE_SLOTS];
  logic [EntryW-1:0] rd_q;
  logic [SLOT_W-1:0] rd_addr;

  logic              op_q;
  logic [KeyW-1:0]   key_q;
  logic [SLOT_W-1:0] pos_q, pos_d, pos_next;
  logic [SLOT_W:0]   steps_q, steps_d;

  logic [CountW-1:0] keys_q, keys_d;
  logic [CountW-1:0] coll_q, coll_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [TotalW:0]   total_sum;

  logic              rsp_valid_q;
  status_e           status_q, status_d;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W:0]   steps_out_q;

  logic hit_empty, hit_match, wrap_full, do_insert, mem_we;
  logic [EntryW-1:0] wr_data;

  assign pos_next  = pos_q + SLOT_W'(ProbeStride);
  assign hit_empty = ~rd_q[KeyW];
  assign hit_match = rd_q[KeyW] & (rd_q[KeyW-1:0] == key_q);
  assign wrap_full = rd_q[KeyW] & ~hit_match &
                     (steps_q == (SLOT_W+1)'(TABLE_SLOTS - 1));
  assign do_insert = (op_q == OP_INSERT) & hit_empty;

  assign stat_o.clear_last = (pos_q == {SLOT_W{1'b1}});
  assign stat_o.hit_empty  = hit_empty;
  assign stat_o.hit_match  = hit_match;
  assign stat_o.wrap_full  = wrap_full;
  assign stat_o.out_free   = ~rsp_valid_q | rsp_ready_i;

  // read address: home slot on load, next slot on advance, else hold
  always_comb begin
    if (cmd_i.load) begin
      rd_addr = hash_i[SLOT_W-1:0];
    end else if (cmd_i.advance) begin
      rd_addr = pos_next;
    end else begin
      rd_addr = pos_q;
    end
  end

  assign mem_we  = cmd_i.clear_step | (cmd_i.finish & do_insert);
  assign wr_data = cmd_i.clear_step ? '0 : {1'b1, key_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) key_mem[pos_q] <= wr_data;
    rd_q <= key_mem[rd_addr];
  end

  always_comb begin
    pos_d   = pos_q;
    steps_d = steps_q;
    if (cmd_i.load) begin
      pos_d   = hash_i[SLOT_W-1:0];
      steps_d = '0;
    end else if (cmd_i.advance || cmd_i.clear_step) begin
      pos_d   = pos_next;
      steps_d = steps_q + 1'b1;
    end
  end

  always_comb begin
    if (hit_match) begin
      status_d = (op_q == OP_INSERT) ? ST_PRESENT : ST_FOUND;
    end else if (op_q == OP_LOOKUP) begin
      status_d = ST_MISSING;
    end else if (wrap_full) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_INSERTED;
    end
  end

  // counters move only on a successful insert; all saturate
  assign total_sum = {1'b0, total_q} + (TotalW+1)'(steps_q);
  always_comb begin
    keys_d  = keys_q;
    coll_d  = coll_q;
    total_d = total_q;
    if (do_insert) begin
      keys_d = (keys_q == {CountW{1'b1}}) ? keys_q : keys_q + 1'b1;
      if (steps_q != '0) begin
        coll_d  = (coll_q == {CountW{1'b1}}) ? coll_q : coll_q + 1'b1;
        total_d = total_sum[TotalW] ? {TotalW{1'b1}} : total_sum[TotalW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      keys_q      <= '0;
      coll_q      <= '0;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (cmd_i.finish) begin
        keys_q      <= keys_d;
        coll_q      <= coll_d;
        total_q     <= total_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d;
    if (cmd_i.load) begin
      op_q  <= op_i;
      key_q <= key_i;
    end
    if (cmd_i.finish) begin
      status_q    <= status_d;
      slot_q      <= wrap_full ? pos_next : pos_q;
      steps_out_q <= wrap_full ? steps_q + 1'b1 : steps_q;
    end
  end

  assign rsp_valid_o         = rsp_valid_q;
  assign status_o            = status_q;
  assign slot_index_o        = slot_q;
  assign probe_steps_o       = steps_out_q;
  assign key_count_o         = keys_q;
  assign collision_count_o   = coll_q;
  assign total_probe_count_o = total_q;

endmodule

[rtl/linear_probe_hash_set.sv]
// Open-addressing set of 64-bit keys with linear probing over a single
// TABLE_SLOTS-entry slot memory (one read and one write port). After reset
// the block runs a clearing pass over all TABLE_SLOTS slots, one slot per cycle,
// and takes no request until it ends. A request issues the read of its home
// slot when it is taken, then examines one slot per read of the slot memory
// and holds on the last slot while the result register is still full. The
// next request is taken in the cycle after the result is registered; the
// result register lets it wait for the sink.
// depends on lphs_pkg, lphs_if, lphs_ctrl, lphs_datapath
module linear_probe_hash_set
  import lphs_pkg::*;
#(
  parameter int TABLE_SLOTS = DefaultTableSlots
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lphs_req_if.sink   req_i,
  lphs_rsp_if.source rsp_o
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);

  cmd_t  cmd;
  stat_t stat;

  lphs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lphs_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .op_i                (req_i.operation),
    .key_i               (req_i.key_value),
    .hash_i              (req_i.key_hash),
    .rsp_ready_i         (rsp_o.ready),
    .rsp_valid_o         (rsp_o.valid),
    .status_o            (rsp_o.status),
    .slot_index_o        (rsp_o.slot_index),
    .probe_steps_o       (rsp_o.probe_steps),
    .key_count_o         (rsp_o.key_count),
    .collision_count_o   (rsp_o.collision_count),
    .total_probe_count_o (rsp_o.total_probe_count)
  );

  // one request in flight: a transfer in closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // a full table means every slot was stepped past
  a_full_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_FULL |->
      rsp_o.probe_steps == (SLOT_W+1)'(TABLE_SLOTS))
    else $error("full status without a complete wrap");

  // a fresh insert leaves at least one key stored
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) && rsp_o.status == ST_INSERTED |->
      rsp_o.key_count != '0)
    else $error("insert reported with zero stored keys");

endmodule

[test/lphs_tb_pkg.sv]
// lphs_tb_pkg: shadow copy of the hash set, used to predict and check every reply
// depends on lphs_pkg; imported by tb_linear_probe_hash_set
package lphs_tb_pkg;
  import lphs_pkg::*;

  localparam int Slots    = DefaultTableSlots;
  localparam int SlotW    = $clog2(Slots);
  localparam int CountMax = (1 << CountW) - 1;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  slot;
    logic [SlotW:0]    steps;
    logic [CountW-1:0] keys;
    logic [CountW-1:0] collisions;
    logic [TotalW-1:0] probes;
  } reply_t;

  class hash_set_shadow;
    logic [KeyW-1:0]   slot_key [Slots];
    bit                occupied [Slots];
    int unsigned       stored_keys;
    int unsigned       colliding_inserts;
    logic [TotalW-1:0] probe_total;
    reply_t            replies_due[$];
    int unsigned       requests;
    int unsigned       checked;
    int unsigned       mismatches;
    int unsigned       status_seen [5];
    int unsigned       longest_run;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      stored_keys       = 0;
      colliding_inserts = 0;
      probe_total       = '0;
      requests          = 0;
      checked           = 0;
      mismatches        = 0;
      longest_run       = 0;
    endfunction

    // walk the table as the block does and queue the reply it must give
    function void accept_request(op_e op, logic [KeyW-1:0] key, logic [HashW-1:0] hash);
      int unsigned     pos;
      int unsigned     steps;
      bit              matched;
      longint unsigned sum;
      reply_t          want;
      pos     = hash % Slots;
      steps   = 0;
      matched = 1'b0;
      while (!matched && steps < Slots && occupied[pos]) begin
        if (slot_key[pos] == key) begin
          matched = 1'b1;
        end else begin
          pos = (pos + ProbeStride) % Slots;
          steps++;
        end
      end
      if (matched) begin
        want.status = (op == OP_INSERT) ? ST_PRESENT : ST_FOUND;
      end else if (op == OP_LOOKUP) begin
        want.status = ST_MISSING;
      end else if (steps >= Slots) begin
        want.status = ST_FULL;
      end else begin
        want.status    = ST_INSERTED;
        slot_key[pos]  = key;
        occupied[pos]  = 1'b1;
        if (stored_keys < CountMax) stored_keys++;
        if (steps > 0) begin
          if (colliding_inserts < CountMax) colliding_inserts++;
          sum         = longint'(probe_total) + steps;
          probe_total = (sum > 64'hFFFF_FFFF) ? '1 : sum[TotalW-1:0];
        end
      end
      want.slot       = pos[SlotW-1:0];
      want.steps      = steps[SlotW:0];
      want.keys       = stored_keys[CountW-1:0];
      want.collisions = colliding_inserts[CountW-1:0];
      want.probes     = probe_total;
      replies_due.push_back(want);
      requests++;
      status_seen[int'(want.status)]++;
      if (steps > longest_run) longest_run = steps;
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] reply with nothing outstanding: st=%0d slot=%0d steps=%0d",
                   $time, got.status, got.slot, got.steps);
      end else begin
        want = replies_due.pop_front();
        checked++;
        if (got.status !== want.status || got.slot !== want.slot ||
            got.steps !== want.steps || got.keys !== want.keys ||
            got.collisions !== want.collisions || got.probes !== want.probes) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] reply %0d wrong: want st=%0d slot=%0d steps=%0d keys=%0d coll=%0d probes=%0d",
                     $time, checked, want.status, want.slot, want.steps, want.keys,
                     want.collisions, want.probes);
            $display("    got  st=%0d slot=%0d steps=%0d keys=%0d coll=%0d probes=%0d",
                     got.status, got.slot, got.steps, got.keys, got.collisions, got.probes);
          end
        end
      end
    endfunction
  endclass

endpackage

[test/tb_linear_probe_hash_set.sv]
// tb_linear_probe_hash_set: directed and random inserts and lookups, filled up to a full table
// depends on lphs_pkg, lphs_if, lphs_tb_pkg and the linear_probe_hash_set rtl
module tb_linear_probe_hash_set;
  import lphs_pkg::*;
  import lphs_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
  } known_key_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   steady = 1'b0;
  int unsigned sent = 0;

  hash_set_shadow shadow = new();
  known_key_t     known[$];
  reply_t         rsp_seen;

  lphs_req_if                    req_if ();
  lphs_rsp_if #(.SLOT_W(SlotW))  rsp_if ();

  linear_probe_hash_set #(
    .TABLE_SLOTS(Slots)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 17);
  endfunction

  // mostly hot spots and reused hashes so that probe runs grow long
  function automatic logic [HashW-1:0] pick_hash();
    int unsigned hot [4] = '{0, 300, 700, Slots - 4};
    logic [HashW-1:0] h;
    int unsigned      pick;
    h    = $urandom;
    pick = $urandom_range(0, 9);
    if (pick >= 4 && pick <= 6) begin
      h = h - (h % Slots) + ((hot[$urandom_range(0, 3)] + $urandom_range(0, 7)) % Slots);
    end else if (pick > 6 && known.size() != 0) begin
      h = known[$urandom_range(0, known.size() - 1)].hash;
    end
    return h;
  endfunction

  task automatic send_request(input op_e op, input logic [KeyW-1:0] key,
                              input logic [HashW-1:0] hash);
    int unsigned gap;
    known_key_t  entry;
    gap = draw_wait();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.key_value <= key;
    req_if.key_hash  <= hash;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    shadow.accept_request(op, key, hash);
    if (op == OP_INSERT) begin
      entry.key  = key;
      entry.hash = hash;
      known.push_back(entry);
    end
    sent++;
    if (sent % 50 == 0) steady = ($urandom_range(0, 3) == 0);
  endtask

  // hold off new requests until every outstanding reply has come back
  task automatic drain_replies();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (shadow.replies_due.size() != 0);
  endtask

  task automatic lookup_known();
    known_key_t entry;
    entry = known[$urandom_range(0, known.size() - 1)];
    send_request(OP_LOOKUP, entry.key, entry.hash);
  endtask

  task automatic reinsert_known(input bit other_hash);
    known_key_t entry;
    entry = known[$urandom_range(0, known.size() - 1)];
    send_request(OP_INSERT, entry.key, other_hash ? pick_hash() : entry.hash);
  endtask

  // receiving side: random stall before each transfer
  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      rsp_seen.status     = rsp_if.status;
      rsp_seen.slot       = rsp_if.slot_index;
      rsp_seen.steps      = rsp_if.probe_steps;
      rsp_seen.keys       = rsp_if.key_count;
      rsp_seen.collisions = rsp_if.collision_count;
      rsp_seen.probes     = rsp_if.total_probe_count;
      shadow.check_reply(rsp_seen);
    end
  end

  initial begin
    int unsigned pick;
    int unsigned fill_items;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_LOOKUP;
    req_if.key_value <= '0;
    req_if.key_hash  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // edges of the fields, wrap past the last slot, duplicate keys under other hashes
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, '1, '0);
    send_request(OP_INSERT, '1, '0);
    send_request(OP_LOOKUP, '0, 32'hFFFF_FC00);
    send_request(OP_LOOKUP, '1, '1);
    send_request(OP_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, '1);
    send_request(OP_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 32'(Slots - 1));
    send_request(OP_LOOKUP, 64'h5A5A_5A5A_5A5A_5A5A, 32'h8000_0000);
    send_request(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'(Slots - 1));
    send_request(OP_INSERT, '0, 32'd5);
    send_request(OP_LOOKUP, '0, 32'd5);
    send_request(OP_INSERT, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 64'h0000_0000_0000_0001, 32'h7FFF_FFFF);
    send_request(OP_LOOKUP, 64'h0000_0000_0000_0001, 32'h7FFF_FFFF);
    send_request(OP_LOOKUP, 64'hFFFF_FFFF_0000_0000, 32'h5555_5555);
    send_request(OP_INSERT, 64'h0000_0000_FFFF_FFFF, 32'hAAAA_AAAA);
    send_request(OP_INSERT, 64'h0000_0000_FFFF_FFFF, 32'hAAAA_AAAA);
    drain_replies();

    // fill the table, mostly new keys
    fill_items = 0;
    while (shadow.stored_keys < Slots && fill_items < 4 * Slots) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) send_request(OP_INSERT, {$urandom, $urandom}, pick_hash());
      else if (pick < 92) reinsert_known(pick == 91);
      else if (pick < 97) lookup_known();
      else send_request(OP_LOOKUP, {$urandom, $urandom}, $urandom);
      fill_items++;
    end
    drain_replies();

    // every slot taken: new keys report full, misses wrap the whole table
    repeat (40) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) send_request(OP_INSERT, {$urandom, $urandom}, $urandom);
      else if (pick < 6) reinsert_known(1'b0);
      else if (pick < 8) lookup_known();
      else send_request(OP_LOOKUP, {$urandom, $urandom}, $urandom);
    end
    drain_replies();
    repeat (Slots + 16) @(posedge clk);

    $display("%0d requests: %0d inserted, %0d already present, %0d found, %0d not found, %0d full",
             shadow.requests, shadow.status_seen[ST_INSERTED], shadow.status_seen[ST_PRESENT],
             shadow.status_seen[ST_FOUND], shadow.status_seen[ST_MISSING],
             shadow.status_seen[ST_FULL]);
    $display("longest probe run %0d slots, %0d replies checked, %0d mismatches, %0d outstanding",
             shadow.longest_run, shadow.checked, shadow.mismatches, shadow.replies_due.size());
    if (shadow.mismatches == 0 && shadow.replies_due.size() == 0) begin
      $display("tb_linear_probe_hash_set: done, clean");
    end else begin
      $display("tb_linear_probe_hash_set: done, errors");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d replies outstanding", shadow.replies_due.size());
    $display("tb_linear_probe_hash_set: done, errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/lphs_pkg.sv
rtl/lphs_if.sv
rtl/lphs_ctrl.sv
rtl/lphs_datapath.sv
rtl/linear_probe_hash_set.sv
test/lphs_tb_pkg.sv
test/tb_linear_probe_hash_set.sv
